>>> design/pidd_pkg.sv
// shared constants, codes and saturation helper for the pid axis controller
`default_nettype none

package pidd_pkg;

    // word and fixed-point format
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // serial multiplier geometry: 33-bit multiplicand, 36-bit multiplier, 4-bit digits
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 36;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = MUL_B_W / DIGIT_W;
    localparam int ACC_W      = 40;
    localparam int PROD_SH_W  = ACC_W + MUL_B_W - FRAC_W;
    localparam int SUM_W      = 52;

    localparam logic [3:0] LAST_STEP = 4'(NUM_DIGITS - 1);

    // 2*pi approximated as 6.284, in Q16.16, rounded to nearest
    localparam logic signed [33:0] TWO_PI_FIX = 34'sd411828;

    // axis modes
    localparam logic [1:0] MODE_YAW = 2'd1;
    localparam logic [1:0] MODE_ALT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_GAIN_DD    = 3'd3;
    localparam logic [2:0] REG_PERIOD     = 3'd4;
    localparam logic [2:0] REG_RATE_SCALE = 3'd5;
    localparam logic [2:0] REG_INT_LIMIT  = 3'd6;
    localparam logic [2:0] REG_AXIS_MODE  = 3'd7;

    // input opcodes
    localparam logic OP_CLEAR = 1'b1;

    // multiplier pass order
    localparam logic [2:0] MUL_RATE  = 3'd0;
    localparam logic [2:0] MUL_INTEG = 3'd1;
    localparam logic [2:0] MUL_P     = 3'd2;
    localparam logic [2:0] MUL_I     = 3'd3;
    localparam logic [2:0] MUL_D     = 3'd4;
    localparam logic [2:0] MUL_DD    = 3'd5;

    // clamp a wide signed value to one data word
    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [59:0] x);
        if (x > 60'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (x < -60'sd2147483648)
            return 32'sh8000_0000;
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/pid_dd_axis_controller_core.sv
// one-axis pid controller with second-derivative term, digit-serial datapath
//
// A clear word (opcode 1) zeroes the integral and loads a zero effort into the output
// register once that register is free. A control step runs from acceptance to the output
// register as a preparation step, then six passes through one shared signed multiplier
// that consumes the multiplier operand four bits per cycle (a load, nine digit steps
// and a post-processing step each), then the result load. The result load waits while
// the output register still holds an unaccepted word. The input is stalled for the
// whole step; the output register lets a finished result wait while the next word
// is accepted. Configuration writes take effect at the next edge and are meant to be
// issued only while the block is idle.
`default_nettype none

module pid_dd_axis_controller_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // configuration write port
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,

    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                opcode,
    input  wire logic signed [31:0]  measured,
    input  wire logic signed [31:0]  setpoint,
    input  wire logic signed [31:0]  velocity,
    input  wire logic signed [31:0]  acceleration,

    // output channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       effort
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_POST = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // control state
    logic [2:0] state_reg, state_next;
    logic [2:0] mul_idx_reg, mul_idx_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    // configuration
    logic signed [31:0] gain_p_reg, gain_p_next;
    logic signed [31:0] gain_i_reg, gain_i_next;
    logic signed [31:0] gain_d_reg, gain_d_next;
    logic signed [31:0] gain_dd_reg, gain_dd_next;
    logic [16:0]        period_reg, period_next;
    logic [25:0]        rate_scale_reg, rate_scale_next;
    logic [30:0]        limit_reg, limit_next;
    logic [1:0]         mode_reg, mode_next;

    // controller state
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] prev_sp_reg, prev_sp_next;

    // latched word and intermediate values
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] sp_reg, sp_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] acc_in_reg, acc_in_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [32:0] dsp_reg, dsp_next;
    logic signed [31:0] diff_reg, diff_next;
    logic signed [pidd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [31:0] effort_reg, effort_next;

    // serial multiplier
    logic signed [pidd_pkg::MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic signed [pidd_pkg::MUL_B_W-1:0] mul_b_reg, mul_b_next;
    logic signed [pidd_pkg::ACC_W-1:0]   macc_reg, macc_next;
    logic [pidd_pkg::MUL_B_W-1:0]        lo_reg, lo_next;

    logic signed [4:0]                     digit;
    logic signed [pidd_pkg::MUL_A_W+4:0]   part;
    logic signed [pidd_pkg::ACC_W-1:0]     tsum;
    logic signed [pidd_pkg::PROD_SH_W-1:0] prod_sh;

    // error forming and yaw unwinding
    logic signed [33:0] err0;
    logic signed [33:0] norm;
    logic [33:0]        mag_e;
    logic [33:0]        mag_n;
    logic signed [33:0] err_pick;

    // integral and rate helpers
    logic signed [33:0] int_sum;
    logic signed [33:0] lim_s;
    logic signed [33:0] neg_lim_s;
    logic signed [31:0] rate_w;
    logic signed [pidd_pkg::SUM_W-1:0] term;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign effort    = effort_reg;

    // multiplier digit: top digit carries the sign
    always_comb
    begin
        if (step_reg == pidd_pkg::LAST_STEP)
            digit = $signed({mul_b_reg[3], mul_b_reg[3:0]});
        else
            digit = $signed({1'b0, mul_b_reg[3:0]});
    end

    assign part    = (pidd_pkg::MUL_A_W+5)'(mul_a_reg) * (pidd_pkg::MUL_A_W+5)'(digit);
    assign tsum    = macc_reg + pidd_pkg::ACC_W'(part);
    assign prod_sh = $signed({macc_reg, lo_reg[pidd_pkg::MUL_B_W-1:pidd_pkg::FRAC_W]});
    assign term    = prod_sh[pidd_pkg::SUM_W-1:0];

    // error with optional unwinding by 2*pi
    always_comb
    begin
        err0 = 34'(sp_reg) - 34'(meas_reg);
        if (meas_reg < 0 && sp_reg >= 0)
            norm = err0 + pidd_pkg::TWO_PI_FIX;
        else if (meas_reg >= 0 && sp_reg < 0)
            norm = err0 - pidd_pkg::TWO_PI_FIX;
        else
            norm = err0;
        mag_e = (err0 < 0) ? 34'(-err0) : 34'(err0);
        mag_n = (norm < 0) ? 34'(-norm) : 34'(norm);
        if (mode_reg == pidd_pkg::MODE_YAW && mag_n < mag_e)
            err_pick = norm;
        else
            err_pick = err0;
    end

    // integral accumulate bounds
    assign int_sum   = 34'(integ_reg) + 34'($signed(prod_sh[32:0]));
    assign lim_s     = $signed({3'b000, limit_reg});
    assign neg_lim_s = -lim_s;

    // setpoint rate, zero in altitude mode
    always_comb
    begin
        rate_w = pidd_pkg::sat_word(60'(prod_sh));
        if (mode_reg == pidd_pkg::MODE_ALT)
            rate_w = '0;
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        mul_idx_next    = mul_idx_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        gain_dd_next    = gain_dd_reg;
        period_next     = period_reg;
        rate_scale_next = rate_scale_reg;
        limit_next      = limit_reg;
        mode_next       = mode_reg;
        integ_next      = integ_reg;
        prev_sp_next    = prev_sp_reg;
        meas_next       = meas_reg;
        sp_next         = sp_reg;
        vel_next        = vel_reg;
        acc_in_next     = acc_in_reg;
        err_next        = err_reg;
        dsp_next        = dsp_reg;
        diff_next       = diff_reg;
        sum_next        = sum_reg;
        effort_next     = effort_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        macc_next       = macc_reg;
        lo_next         = lo_reg;

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                pidd_pkg::REG_GAIN_P:     gain_p_next     = $signed(cfg_data);
                pidd_pkg::REG_GAIN_I:     gain_i_next     = $signed(cfg_data);
                pidd_pkg::REG_GAIN_D:     gain_d_next     = $signed(cfg_data);
                pidd_pkg::REG_GAIN_DD:    gain_dd_next    = $signed(cfg_data);
                pidd_pkg::REG_PERIOD:     period_next     = cfg_data[16:0];
                pidd_pkg::REG_RATE_SCALE: rate_scale_next = cfg_data[25:0];
                pidd_pkg::REG_INT_LIMIT:  limit_next      = cfg_data[30:0];
                pidd_pkg::REG_AXIS_MODE:  mode_next       = cfg_data[1:0];
                default: ;
            endcase
        end

        // result word taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    meas_next   = measured;
                    sp_next     = setpoint;
                    vel_next    = velocity;
                    acc_in_next = acceleration;
                    if (opcode == pidd_pkg::OP_CLEAR)
                    begin
                        integ_next = '0;
                        sum_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end

            ST_PREP:
            begin
                err_next     = pidd_pkg::sat_word(60'(err_pick));
                dsp_next     = 33'(sp_reg) - 33'(prev_sp_reg);
                prev_sp_next = sp_reg;
                mul_idx_next = pidd_pkg::MUL_RATE;
                state_next   = ST_LOAD;
            end

            // operand selection for the next multiplier pass
            ST_LOAD:
            begin
                case (mul_idx_reg)
                    pidd_pkg::MUL_RATE:
                    begin
                        mul_a_next = dsp_reg;
                        mul_b_next = $signed({10'b0, rate_scale_reg});
                    end
                    pidd_pkg::MUL_INTEG:
                    begin
                        mul_a_next = 33'(err_reg);
                        mul_b_next = $signed({19'b0, period_reg});
                    end
                    pidd_pkg::MUL_P:
                    begin
                        mul_a_next = 33'(gain_p_reg);
                        mul_b_next = 36'(err_reg);
                    end
                    pidd_pkg::MUL_I:
                    begin
                        mul_a_next = 33'(gain_i_reg);
                        mul_b_next = 36'(integ_reg);
                    end
                    pidd_pkg::MUL_D:
                    begin
                        mul_a_next = 33'(gain_d_reg);
                        mul_b_next = 36'(diff_reg);
                    end
                    pidd_pkg::MUL_DD:
                    begin
                        mul_a_next = 33'(gain_dd_reg);
                        mul_b_next = 36'(acc_in_reg);
                    end
                    default:
                    begin
                        mul_a_next = '0;
                        mul_b_next = '0;
                    end
                endcase
                macc_next  = '0;
                step_next  = '0;
                state_next = ST_MUL;
            end

            // one four-bit digit per cycle, low product bits shift out
            ST_MUL:
            begin
                macc_next  = tsum >>> pidd_pkg::DIGIT_W;
                lo_next    = {tsum[pidd_pkg::DIGIT_W-1:0],
                              lo_reg[pidd_pkg::MUL_B_W-1:pidd_pkg::DIGIT_W]};
                mul_b_next = mul_b_reg >>> pidd_pkg::DIGIT_W;
                step_next  = step_reg + 4'd1;
                if (step_reg == pidd_pkg::LAST_STEP)
                    state_next = ST_POST;
            end

            // consume the finished product
            ST_POST:
            begin
                case (mul_idx_reg)
                    pidd_pkg::MUL_RATE:
                        diff_next = pidd_pkg::sat_word(60'(rate_w) - 60'(vel_reg));
                    pidd_pkg::MUL_INTEG:
                    begin
                        if (int_sum > lim_s)
                            integ_next = lim_s[31:0];
                        else if (int_sum < neg_lim_s)
                            integ_next = neg_lim_s[31:0];
                        else
                            integ_next = int_sum[31:0];
                    end
                    pidd_pkg::MUL_P:  sum_next = term;
                    pidd_pkg::MUL_I:  sum_next = sum_reg + term;
                    pidd_pkg::MUL_D:  sum_next = sum_reg + term;
                    pidd_pkg::MUL_DD: sum_next = sum_reg - term;
                    default: ;
                endcase
                if (mul_idx_reg == pidd_pkg::MUL_DD)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_idx_next = mul_idx_reg + 3'd1;
                    state_next   = ST_LOAD;
                end
            end

            // load the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    effort_next    = pidd_pkg::sat_word(60'(sum_reg));
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mul_idx_reg    <= pidd_pkg::MUL_RATE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            gain_dd_reg    <= '0;
            period_reg     <= 17'd655;
            rate_scale_reg <= 26'd6553600;
            limit_reg      <= 31'd65536;
            mode_reg       <= '0;
            integ_reg      <= '0;
            prev_sp_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mul_idx_reg    <= mul_idx_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            gain_dd_reg    <= gain_dd_next;
            period_reg     <= period_next;
            rate_scale_reg <= rate_scale_next;
            limit_reg      <= limit_next;
            mode_reg       <= mode_next;
            integ_reg      <= integ_next;
            prev_sp_reg    <= prev_sp_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        sp_reg     <= sp_next;
        vel_reg    <= vel_next;
        acc_in_reg <= acc_in_next;
        err_reg    <= err_next;
        dsp_reg    <= dsp_next;
        diff_reg   <= diff_next;
        sum_reg    <= sum_next;
        effort_reg <= effort_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        macc_reg   <= macc_next;
        lo_reg     <= lo_next;
    end

endmodule

`default_nettype wire

>>> dv/pid_dd_axis_controller_core_test.sv
// self-checking testbench for the one-axis pid controller with second-derivative term

// tracks controller state and configuration, predicts each effort word and checks it
class effort_predictor;
    localparam longint TWO_PI_Q16 = ((longint'(6284) << 16) + 500) / 1000;
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam int MAX_PRINTED = 40;

    longint kp, ki, kd, kdd;
    longint period, rate_scale, int_limit;
    logic [1:0] mode;
    longint integral, last_setpoint;
    logic signed [31:0] pending_efforts[$];
    int mismatches;

    function new();
        kp = 0;
        ki = 0;
        kd = 0;
        kdd = 0;
        period = 655;
        rate_scale = 6553600;
        int_limit = 65536;
        mode = 2'd0;
        integral = 0;
        last_setpoint = 0;
        mismatches = 0;
    endfunction

    // clamp to one signed data word
    function longint clamp_word(longint x);
        if (x > WORD_HI)
            return WORD_HI;
        if (x < WORD_LO)
            return WORD_LO;
        return x;
    endfunction

    // exact product, floored back to q16.16
    function longint scale_q(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function longint magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            pidd_pkg::REG_GAIN_P:     kp = longint'($signed(data));
            pidd_pkg::REG_GAIN_I:     ki = longint'($signed(data));
            pidd_pkg::REG_GAIN_D:     kd = longint'($signed(data));
            pidd_pkg::REG_GAIN_DD:    kdd = longint'($signed(data));
            pidd_pkg::REG_PERIOD:     period = longint'(data[16:0]);
            pidd_pkg::REG_RATE_SCALE: rate_scale = longint'(data[25:0]);
            pidd_pkg::REG_INT_LIMIT:  int_limit = longint'(data[30:0]);
            pidd_pkg::REG_AXIS_MODE:  mode = data[1:0];
            default:                  ;
        endcase
    endfunction

    // one accepted input word: update state and queue the expected effort
    function void take_word(logic op, logic signed [31:0] m, logic signed [31:0] s,
                            logic signed [31:0] v, logic signed [31:0] a);
        longint meas, sp, vel, acc, err, unwound, rate, diff, sum;
        logic signed [31:0] want;
        if (op == pidd_pkg::OP_CLEAR)
        begin
            integral = 0;
            pending_efforts.push_back('0);
            return;
        end
        meas = m;
        sp = s;
        vel = v;
        acc = a;

        err = sp - meas;
        rate = clamp_word(scale_q(sp - last_setpoint, rate_scale));
        last_setpoint = sp;

        // yaw: try the error shifted by a full turn, keep it only if strictly smaller
        if (mode == pidd_pkg::MODE_YAW)
        begin
            unwound = err;
            if (meas < 0 && sp >= 0)
                unwound = unwound + TWO_PI_Q16;
            else if (meas >= 0 && sp < 0)
                unwound = unwound - TWO_PI_Q16;
            if (magnitude(unwound) < magnitude(err))
                err = unwound;
        end
        err = clamp_word(err);

        // integrate and clamp symmetrically
        integral = integral + scale_q(err, period);
        if (integral > int_limit)
            integral = int_limit;
        else if (integral < -int_limit)
            integral = -int_limit;

        if (mode == pidd_pkg::MODE_ALT)
            rate = 0;

        diff = clamp_word(rate - vel);
        sum = scale_q(kp, err) + scale_q(ki, integral) + scale_q(kd, diff)
            - scale_q(kdd, acc);
        want = 32'(clamp_word(sum));
        pending_efforts.push_back(want);
    endfunction

    task report(string what);
        if (mismatches < MAX_PRINTED)
            $display("%s", what);
        mismatches++;
    endtask

    // compare one accepted effort word with the oldest expectation
    task check_effort(logic signed [31:0] got);
        logic signed [31:0] want;
        if (pending_efforts.size() == 0)
        begin
            report($sformatf("effort %0d (%h) arrived with no word pending", got, got));
            return;
        end
        want = pending_efforts.pop_front();
        if (got !== want)
            report($sformatf("effort mismatch: got %0d (%h) expected %0d (%h)",
                             got, got, want, want));
    endtask
endclass

module pid_dd_axis_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_STEP = ~pidd_pkg::OP_CLEAR;
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int ONE = 65536;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam int NEAR_SPAN = 4 * ONE;
    localparam int BIG_SPAN = 64 * ONE;
    localparam int DRIFT = 4096;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int SETTLE_CYCLES = 4;
    localparam int FINAL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic opcode;
    logic signed [31:0] measured;
    logic signed [31:0] setpoint;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] effort;

    effort_predictor predictor;
    bit quiet_phase;

    pid_dd_axis_controller_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .measured     (measured),
        .setpoint     (setpoint),
        .velocity     (velocity),
        .acceleration (acceleration),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .effort       (effort)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // operand mix: full range, extremes, near zero and moderate values
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1:
                return $urandom;
            2:
                case ($urandom_range(0, 4))
                    0:       return WORD_MAX;
                    1:       return WORD_MIN;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            3, 4:
                return int'($urandom_range(0, 2 * BIG_SPAN)) - BIG_SPAN;
            default:
                return int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            2, 3:    return int'($urandom_range(0, 2 * DRIFT)) - DRIFT;
            default: return int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
        endcase
    endfunction

    // present one word, after a random gap outside quiet phases, and hold it until accepted
    task automatic send_word(input logic op, input logic signed [31:0] m,
                             input logic signed [31:0] s, input logic signed [31:0] v,
                             input logic signed [31:0] a);
        int gap;
        int r;
        gap = 0;
        if (!quiet_phase)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(10, 40);
            else if (r >= 45)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        measured <= m;
        setpoint <= s;
        velocity <= v;
        acceleration <= a;
        // stall is settled at the falling edge and holds through the next rising edge
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        predictor.take_word(op, m, s, v, a);
        @(posedge clk);
    endtask

    // stop sending and wait until every expected effort has come back
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        while (predictor.pending_efforts.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        predictor.set_reg(idx, data);
    endtask

    // full register set, written only with the block idle
    task automatic apply_setting(input logic [31:0] gp, input logic [31:0] gi,
                                 input logic [31:0] gd, input logic [31:0] gdd,
                                 input logic [31:0] per, input logic [31:0] rate,
                                 input logic [31:0] lim, input logic [1:0] mode);
        drain(SETTLE_CYCLES);
        write_reg(pidd_pkg::REG_GAIN_P, gp);
        write_reg(pidd_pkg::REG_GAIN_I, gi);
        write_reg(pidd_pkg::REG_GAIN_D, gd);
        write_reg(pidd_pkg::REG_GAIN_DD, gdd);
        write_reg(pidd_pkg::REG_PERIOD, per);
        write_reg(pidd_pkg::REG_RATE_SCALE, rate);
        write_reg(pidd_pkg::REG_INT_LIMIT, lim);
        write_reg(pidd_pkg::REG_AXIS_MODE, {30'b0, mode});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_setting();
        logic [31:0] per;
        logic [31:0] rate;
        logic [31:0] lim;
        case ($urandom_range(0, 9))
            0:       per = 1;
            1:       per = 32'h1_0000;
            2, 3:    per = $urandom_range(1, 32'h1_0000);
            default: per = $urandom_range(1, 6554);
        endcase
        case ($urandom_range(0, 9))
            0:       rate = 1;
            1:       rate = 65536000;
            2:       rate = $urandom_range(1, 65536000);
            default: rate = $urandom_range(ONE, 1000 * ONE);
        endcase
        case ($urandom_range(0, 9))
            0:       lim = 0;
            1:       lim = 32'h7FFF_FFFF;
            2, 3:    lim = $urandom_range(0, 32'h7FFF_FFFF);
            default: lim = $urandom_range(0, 32'h10_0000);
        endcase
        apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(), per, rate, lim,
                      2'($urandom_range(0, 3)));
    endtask

    // result side: sample before the edge, check at the edge, stall at random outside quiet phases
    initial
    begin : result_sink
        logic hit;
        logic signed [31:0] got;
        int hold;
        int r;
        out_stall <= 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            hit = (rst_n === 1'b1) && (out_valid === 1'b1) && !out_stall;
            got = effort;
            @(posedge clk);
            if (hit)
                predictor.check_effort(got);
            if (hold > 0)
                hold--;
            else if (!quiet_phase)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    hold = $urandom_range(1, 3);
                else if (r < 33)
                    hold = $urandom_range(15, 45);
            end
            out_stall <= (hold > 0);
        end
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("pid_dd_axis_controller_core_test NOT OK");
        $finish;
    end

    // stimulus
    initial
    begin
        logic signed [31:0] sp;
        logic signed [31:0] meas;
        predictor = new();
        quiet_phase = 1'b0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= pidd_pkg::REG_GAIN_P;
        cfg_data <= '0;
        in_valid <= 1'b0;
        opcode <= OP_STEP;
        measured <= '0;
        setpoint <= '0;
        velocity <= '0;
        acceleration <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: zero gains, integral still moves
        send_word(OP_STEP, ONE, 2 * ONE, ONE, -ONE);
        send_word(OP_STEP, 0, 0, 0, 0);
        send_word(pidd_pkg::OP_CLEAR, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);

        // moderate gains: wide error, wide setpoint rate and wide rate error
        apply_setting(ONE, ONE / 2, ONE / 4, ONE / 8, 655, 6553600, ONE, MODE_PLAIN);
        send_word(OP_STEP, ONE / 2, ONE, ONE / 4, ONE / 16);
        send_word(OP_STEP, WORD_MIN, WORD_MAX, 0, 0);
        send_word(OP_STEP, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX);
        send_word(OP_STEP, 0, WORD_MIN, WORD_MIN, WORD_MIN);
        send_word(pidd_pkg::OP_CLEAR, 0, 0, 0, 0);
        send_word(OP_STEP, -1, -1, -1, -1);

        // extreme gains and registers: effort overflow both ways
        apply_setting(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 32'h1_0000, 65536000,
                      32'h7FFF_FFFF, MODE_PLAIN);
        send_word(OP_STEP, -1, WORD_MAX, WORD_MIN, WORD_MAX);
        send_word(OP_STEP, 1, -1, 1, -1);
        send_word(OP_STEP, WORD_MIN, WORD_MIN, 0, 0);

        // yaw unwinding across the sign boundary
        apply_setting(ONE, ONE, ONE, ONE, 655, 6553600, 4 * ONE, pidd_pkg::MODE_YAW);
        send_word(OP_STEP, -200000, 200000, 0, 0);
        send_word(OP_STEP, 200000, -200000, 0, 0);
        send_word(OP_STEP, 0, -1, 0, 0);
        send_word(OP_STEP, -1, 0, 0, 0);
        send_word(OP_STEP, WORD_MIN, WORD_MAX, 0, 0);

        // altitude: setpoint rate forced to zero
        apply_setting(2 * ONE, ONE, ONE, ONE / 2, 655, 6553600, ONE, pidd_pkg::MODE_ALT);
        send_word(OP_STEP, ONE, 3 * ONE, ONE, ONE);
        send_word(OP_STEP, ONE, -3 * ONE, -ONE, 0);

        // spare mode with zero period, zero rate scale and zero limit
        apply_setting(ONE, ONE, ONE, ONE, 0, 0, 0, MODE_SPARE);
        send_word(OP_STEP, 0, 5 * ONE, ONE, ONE);
        send_word(OP_STEP, ONE, -ONE, 0, 0);

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_setting();
            quiet_phase = (ph % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_word(pidd_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                else
                begin
                    // mostly a slowly moving setpoint tracked closely, sometimes anything
                    if ($urandom_range(0, 1) != 0)
                        sp = 32'(predictor.last_setpoint)
                           + (int'($urandom_range(0, 2 * DRIFT)) - DRIFT);
                    else
                        sp = pick_operand();
                    if ($urandom_range(0, 1) != 0)
                        meas = sp - (int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
                    else
                        meas = pick_operand();
                    send_word(OP_STEP, meas, sp, pick_operand(), pick_operand());
                end
            end
            quiet_phase = 1'b0;
        end

        drain(FINAL_CYCLES);
        if (predictor.mismatches == 0 && predictor.pending_efforts.size() == 0)
            $display("pid_dd_axis_controller_core_test OK");
        else
            $display("pid_dd_axis_controller_core_test NOT OK");
        $finish;
    end

endmodule
